>>> rtl/core/fps_pkg.sv
// Shared types and constants for the prefix-sum tree block.
// No dependencies; used by fps_engine and fenwick_prefix_sum_tree_top.
package fps_pkg;

    localparam int SIZE   = 65536;
    localparam int IDX_W  = 17;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(SIZE);
    localparam int POS_W  = IDX_W + 1;    // room for pos + lowbit overflow

    localparam logic OP_ADD   = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic ready;       // engine can take an item
        logic res_valid;   // query sum is waiting to be taken
    } fps_status_t;

endpackage

>>> rtl/core/fenwick_prefix_sum_tree_top.sv
// Top level of the binary indexed prefix-sum tree.
// Depends on fps_pkg and fps_engine.

// Binary indexed tree over positions 1 to 65536 of 32-bit wrapping sums, held
// in a single-port-read, single-port-write RAM. An add (operation 0) walks up
// from index, one node read-modify-write per cycle; a query (operation 1)
// walks down and returns one prefix_sum, and also waits while the output
// register is still full. One item is in flight at a time. Adds at index 0
// or above 65536 do nothing, queries at 0 return 0 and queries above 65536
// return the total. After reset the block clears every RAM node and holds
// item_ready low meanwhile. A result waits in an output register, so the
// next item can be taken while result_valid is still pending.
module fenwick_prefix_sum_tree_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic                               operation,
    input  logic [fps_pkg::IDX_W-1:0]          index,
    input  logic signed [fps_pkg::DATA_W-1:0]  delta,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic signed [fps_pkg::DATA_W-1:0]  prefix_sum
);
    import fps_pkg::*;

    fps_status_t       status;
    logic [DATA_W-1:0] res_sum;
    logic              slot_free;
    logic              result_valid_reg;
    logic [DATA_W-1:0] prefix_sum_reg;

    assign slot_free  = !result_valid_reg || result_ready;
    assign item_ready = status.ready;

    fps_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (item_valid && status.ready),
        .operation (operation),
        .index     (index),
        .delta     (delta),
        .res_take  (slot_free),
        .status    (status),
        .res_sum   (res_sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (status.res_valid && slot_free)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.res_valid && slot_free)
        begin
            prefix_sum_reg <= res_sum;
        end
    end

    assign result_valid = result_valid_reg;
    assign prefix_sum   = prefix_sum_reg;

endmodule

>>> rtl/core/fps_engine.sv
// Tree walker: node memory, clearing pass, add/query walk sequencer.
// Depends on fps_pkg.
module fps_engine (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic                        operation,
    input  logic [fps_pkg::IDX_W-1:0]   index,
    input  logic [fps_pkg::DATA_W-1:0]  delta,
    input  logic                        res_take,
    output fps_pkg::fps_status_t        status,
    output logic [fps_pkg::DATA_W-1:0]  res_sum
);
    import fps_pkg::*;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [POS_W-1:0]  SIZE_POS  = POS_W'(SIZE);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(SIZE - 1);

    logic [DATA_W-1:0] mem [SIZE];

    logic [1:0]        state_reg, state_next;
    logic              op_reg, op_next;
    logic [DATA_W-1:0] delta_reg, delta_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;
    logic [DATA_W-1:0] rd_data_reg;

    logic              rd_en, wr_en, issue;
    logic [ADDR_W-1:0] rd_addr, wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [POS_W-1:0]  low_bit, pos_m1, start_pos;

    assign low_bit = pos_reg & (~pos_reg + POS_W'(1));
    assign pos_m1  = pos_reg - POS_W'(1);

    // queries above SIZE saturate; adds out of range simply never issue
    assign start_pos = (operation == OP_QUERY && {1'b0, index} > SIZE_POS)
                     ? SIZE_POS : {1'b0, index};

    assign issue = (pos_reg != '0) && (pos_reg <= SIZE_POS);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        delta_next     = delta_reg;
        pos_next       = pos_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        acc_next       = acc_reg;
        clr_addr_next  = clr_addr_reg;
        rd_en          = 1'b0;
        rd_addr        = pos_m1[ADDR_W-1:0];
        wr_en          = 1'b0;
        wr_addr        = pend_addr_reg;
        wr_data        = rd_data_reg + delta_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en         = 1'b1;
                wr_addr       = clr_addr_reg;
                wr_data       = '0;
                clr_addr_next = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    op_next    = operation;
                    delta_next = delta;
                    pos_next   = start_pos;
                    acc_next   = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                // read one node per cycle; its update lands the next cycle
                if (issue)
                begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = pos_m1[ADDR_W-1:0];
                    pos_next       = (op_reg == OP_QUERY) ? pos_reg - low_bit
                                                          : pos_reg + low_bit;
                end
                if (pend_reg)
                begin
                    if (op_reg == OP_QUERY)
                    begin
                        acc_next = acc_reg + rd_data_reg;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                    end
                end
                if (!issue && !pend_reg)
                begin
                    state_next = (op_reg == OP_QUERY) ? ST_DONE : ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            pend_reg     <= 1'b0;
            clr_addr_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        delta_reg     <= delta_next;
        pos_reg       <= pos_next;
        pend_addr_reg <= pend_addr_next;
        acc_reg       <= acc_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign status.ready     = (state_reg == ST_IDLE);
    assign status.res_valid = (state_reg == ST_DONE);
    assign res_sum          = acc_reg;

`ifndef SYNTH
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && wr_en) |-> (rd_addr != wr_addr))
        else $error("read and write hit the same node");

    a_pend_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg == $past(rd_en))
        else $error("pending data does not match issued read");

    a_query_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && op_reg == OP_QUERY) |-> (pos_reg <= SIZE_POS))
        else $error("query walk left the tree");

    a_done_is_query: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (op_reg == OP_QUERY))
        else $error("result raised for an add");

    a_walk_ends_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK && state_next != ST_WALK) |-> (!rd_en && !wr_en))
        else $error("walk ended with memory traffic in flight");
`endif

endmodule
